// ===== rtl/dfs_pkg.sv =====
`timescale 1ns / 1ps

package dfs_pkg;

  // Offsets and counters
  localparam int OFF_W   = 16;
  localparam int CNT_W   = 16;
  localparam logic [OFF_W-1:0] OFF_MAX  = {OFF_W{1'b1}};
  localparam logic [CNT_W-1:0] NO_LIMIT = {CNT_W{1'b1}};

  // Separator
  localparam int SEP_MAX    = 8;
  localparam int SEP_IDX_W  = $clog2(SEP_MAX);
  localparam int SEP_LEN_W  = 4;
  localparam int SEP_BITS_W = 64;
  localparam int BSM_W      = $clog2(SEP_MAX + 1);

  // Padding
  localparam int MIN_W       = 7;
  localparam int MAX_RESULTS = 64;

  localparam int BYTE_W = 8;
  localparam int CFG_W  = SEP_BITS_W;

  typedef enum logic [1:0] {
    CFG_SEP_BYTES   = 2'd0,
    CFG_SEP_LENGTH  = 2'd1,
    CFG_FIELD_LIMIT = 2'd2,
    CFG_MIN_FIELDS  = 2'd3
  } cfg_idx_t;

  typedef logic [OFF_W-1:0] off_t;

  function automatic off_t sat_inc(input off_t v);
    sat_inc = (v == OFF_MAX) ? v : v + off_t'(1);
  endfunction

endpackage

// ===== rtl/dfs_in_if.sv =====
`timescale 1ns / 1ps

interface dfs_in_if;
  import dfs_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic              byte_valid;
  logic              end_of_string;

  modport source(output valid, output byte_value, output byte_valid, output end_of_string,
                 input ready);
  modport sink(input valid, input byte_value, input byte_valid, input end_of_string,
               output ready);
endinterface

// ===== rtl/dfs_out_if.sv =====
`timescale 1ns / 1ps

interface dfs_out_if;
  import dfs_pkg::*;

  logic             valid;
  logic             ready;
  logic [OFF_W-1:0] field_start;
  logic [OFF_W-1:0] field_end;
  logic             is_padding;
  logic             last_result;

  modport source(output valid, output field_start, output field_end, output is_padding,
                 output last_result, input ready);
  modport sink(input valid, input field_start, input field_end, input is_padding,
               input last_result, output ready);
endinterface

// ===== rtl/delimiter_field_splitter_core.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake     Item
// in_chan   in   valid/ready   byte_value, byte_valid, end_of_string
// out_chan  out  valid/ready   field_start, field_end, is_padding, last_result
// cfg_*     in   cfg_wr_en     cfg_index selects the register, cfg_wr_data carries it
//
// One item is taken per cycle unless string-end results are pending or the output stalls;
// its first result passes from the input register into the output register.
// An item that ends a string with k results holds the input register until its remaining
// results are sent, since the output register sends one result per cycle while out_chan is ready.
// Items that give no result pass the input register while the output stalls, unless results pend.
// Reset is synchronous: it clears the string state and loads the register defaults.

module delimiter_field_splitter_core (
  input  logic                     clk,
  input  logic                     rst_n,
  dfs_in_if.sink                   in_chan,
  dfs_out_if.source                out_chan,
  input  logic                     cfg_wr_en,
  input  dfs_pkg::cfg_idx_t        cfg_index,
  input  logic [dfs_pkg::CFG_W-1:0] cfg_wr_data
);
  import dfs_pkg::*;

  // Configuration
  logic [SEP_MAX-1:0][BYTE_W-1:0] sep_r, sep_nxt;
  logic [SEP_LEN_W-1:0]           sep_len_r, sep_len_nxt;
  logic [CNT_W-1:0]               limit_r, limit_nxt;
  logic [MIN_W-1:0]               min_r, min_nxt;

  // Input register
  logic              a_valid_r, a_valid_nxt;
  logic [BYTE_W-1:0] a_byte_r;
  logic              a_bvalid_r;
  logic              a_end_r;

  // String state
  off_t                             pos_r, pos_nxt;
  off_t                             cfs_r, cfs_nxt;
  logic [CNT_W-1:0]                 fe_r, fe_nxt;
  logic [SEP_MAX-2:0][BYTE_W-1:0]   win_r, win_nxt;
  logic [BSM_W-1:0]                 bsm_r, bsm_nxt;
  logic                             lim_r, lim_nxt;

  // Pending results of a string end
  logic             pend_real_r, pend_real_nxt;
  off_t             pend_start_r, pend_start_nxt;
  off_t             pend_end_r, pend_end_nxt;
  logic [MIN_W-1:0] pend_pad_r, pend_pad_nxt;

  // Output register
  logic out_valid_r, out_valid_nxt;
  off_t out_start_r, out_start_nxt;
  off_t out_end_r, out_end_nxt;
  logic out_pad_r, out_pad_nxt;
  logic out_last_r, out_last_nxt;

  // Item evaluation
  logic [SEP_LEN_W-1:0]           len_eff;
  off_t                           pos_inc;
  logic [BSM_W-1:0]               bsm_inc;
  logic [SEP_MAX-1:0][BYTE_W-1:0] cand;
  logic                           hit;
  logic                           r0v, r1v;
  off_t                           r0_start, r0_end, mstart;
  off_t                           cfs_a, pos_a;
  logic [BSM_W-1:0]               bsm_a;
  logic                           lim_a;
  logic [CNT_W-1:0]               fe1, fe2;
  logic [MIN_W-1:0]               target, pads;
  logic                           no_result;

  logic pend_active, out_load_ok, consume_a, in_acc;

  always_comb begin
    logic [SEP_IDX_W-1:0] idx;
    idx      = '0;
    len_eff  = (sep_len_r > SEP_LEN_W'(SEP_MAX)) ? SEP_LEN_W'(SEP_MAX) : sep_len_r;
    pos_inc  = sat_inc(pos_r);
    bsm_inc  = (bsm_r < BSM_W'(SEP_MAX)) ? bsm_r + BSM_W'(1) : bsm_r;

    // Newest byte at position zero, older bytes behind it.
    cand[0] = a_byte_r;
    for (int j = 1; j < SEP_MAX; j++) begin
      cand[j] = win_r[j-1];
    end

    // The byte j places back must equal separator byte len-1-j.
    hit = 1'b1;
    for (int j = 0; j < SEP_MAX; j++) begin
      idx = SEP_IDX_W'(len_eff - SEP_LEN_W'(1) - SEP_LEN_W'(j));
      if (SEP_LEN_W'(j) < len_eff && cand[j] != sep_r[idx]) begin
        hit = 1'b0;
      end
    end

    mstart = (pos_inc >= off_t'(len_eff)) ? pos_inc - off_t'(len_eff) : '0;
    if (mstart < cfs_r) begin
      mstart = cfs_r;
    end

    r0v      = 1'b0;
    r0_start = cfs_r;
    r0_end   = mstart;
    cfs_a    = cfs_r;
    pos_a    = pos_r;
    bsm_a    = bsm_r;
    lim_a    = lim_r;

    if (a_bvalid_r) begin
      pos_a = pos_inc;
      if (len_eff == '0) begin
        r0v      = (limit_r != '0);
        r0_start = pos_r;
        r0_end   = pos_inc;
      end else begin
        bsm_a = bsm_inc;
        if (!lim_r && limit_r != '0 && bsm_inc >= BSM_W'(len_eff) && hit) begin
          if (limit_r != NO_LIMIT &&
              ({1'b0, fe_r} + (CNT_W+1)'(1)) >= {1'b0, limit_r}) begin
            lim_a = 1'b1;
          end else begin
            r0v   = 1'b1;
            cfs_a = pos_inc;
            bsm_a = '0;
          end
        end
      end
    end

    fe1 = (r0v && fe_r != NO_LIMIT) ? fe_r + CNT_W'(1) : fe_r;
    r1v = a_end_r && limit_r != '0 && len_eff != '0;
    fe2 = (r1v && fe1 != NO_LIMIT) ? fe1 + CNT_W'(1) : fe1;

    target = (min_r > MIN_W'(MAX_RESULTS)) ? MIN_W'(MAX_RESULTS) : min_r;
    pads   = (a_end_r && fe2 < CNT_W'(target)) ? target - MIN_W'(fe2) : '0;
    no_result = !r0v && !r1v && pads == '0;
  end

  assign pend_active = pend_real_r || (pend_pad_r != '0);
  assign out_load_ok = !out_valid_r || out_chan.ready;
  assign consume_a   = a_valid_r && !pend_active && (no_result || out_load_ok);
  assign in_chan.ready = !a_valid_r || consume_a;
  assign in_acc      = in_chan.valid && in_chan.ready;

  always_comb begin
    sep_nxt     = sep_r;
    sep_len_nxt = sep_len_r;
    limit_nxt   = limit_r;
    min_nxt     = min_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SEP_BYTES:   sep_nxt     = cfg_wr_data;
        CFG_SEP_LENGTH:  sep_len_nxt = cfg_wr_data[SEP_LEN_W-1:0];
        CFG_FIELD_LIMIT: limit_nxt   = cfg_wr_data[CNT_W-1:0];
        CFG_MIN_FIELDS:  min_nxt     = cfg_wr_data[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    a_valid_nxt = (a_valid_r && !consume_a) || in_acc;

    pos_nxt = pos_r;
    cfs_nxt = cfs_r;
    fe_nxt  = fe_r;
    win_nxt = win_r;
    bsm_nxt = bsm_r;
    lim_nxt = lim_r;

    pend_real_nxt  = pend_real_r;
    pend_start_nxt = pend_start_r;
    pend_end_nxt   = pend_end_r;
    pend_pad_nxt   = pend_pad_r;

    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_start_nxt = out_start_r;
    out_end_nxt   = out_end_r;
    out_pad_nxt   = out_pad_r;
    out_last_nxt  = out_last_r;

    if (pend_active) begin
      if (out_load_ok) begin
        out_valid_nxt = 1'b1;
        if (pend_real_r) begin
          out_start_nxt = pend_start_r;
          out_end_nxt   = pend_end_r;
          out_pad_nxt   = 1'b0;
          out_last_nxt  = (pend_pad_r == '0);
          pend_real_nxt = 1'b0;
        end else begin
          out_start_nxt = '0;
          out_end_nxt   = '0;
          out_pad_nxt   = 1'b1;
          out_last_nxt  = (pend_pad_r == MIN_W'(1));
          pend_pad_nxt  = pend_pad_r - MIN_W'(1);
        end
      end
    end else if (consume_a) begin
      if (!no_result) begin
        out_valid_nxt = 1'b1;
        pend_start_nxt = cfs_a;
        pend_end_nxt   = pos_a;
        pend_pad_nxt   = pads;
        if (r0v) begin
          out_start_nxt = r0_start;
          out_end_nxt   = r0_end;
          out_pad_nxt   = 1'b0;
          pend_real_nxt = r1v;
        end else if (r1v) begin
          out_start_nxt = cfs_a;
          out_end_nxt   = pos_a;
          out_pad_nxt   = 1'b0;
          pend_real_nxt = 1'b0;
        end else begin
          out_start_nxt = '0;
          out_end_nxt   = '0;
          out_pad_nxt   = 1'b1;
          pend_real_nxt = 1'b0;
          pend_pad_nxt  = pads - MIN_W'(1);
        end
        out_last_nxt = a_end_r && !pend_real_nxt && pend_pad_nxt == '0;
      end

      if (a_end_r) begin
        pos_nxt = '0;
        cfs_nxt = '0;
        fe_nxt  = '0;
        win_nxt = '0;
        bsm_nxt = '0;
        lim_nxt = 1'b0;
      end else begin
        pos_nxt = pos_a;
        cfs_nxt = cfs_a;
        fe_nxt  = fe1;
        bsm_nxt = bsm_a;
        lim_nxt = lim_a;
        if (a_bvalid_r) begin
          win_nxt = {win_r[SEP_MAX-3:0], a_byte_r};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r       <= SEP_BITS_W'(44);
      sep_len_r   <= SEP_LEN_W'(1);
      limit_r     <= NO_LIMIT;
      min_r       <= '0;
      a_valid_r   <= 1'b0;
      pos_r       <= '0;
      cfs_r       <= '0;
      fe_r        <= '0;
      win_r       <= '0;
      bsm_r       <= '0;
      lim_r       <= 1'b0;
      pend_real_r <= 1'b0;
      pend_pad_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sep_r       <= sep_nxt;
      sep_len_r   <= sep_len_nxt;
      limit_r     <= limit_nxt;
      min_r       <= min_nxt;
      a_valid_r   <= a_valid_nxt;
      pos_r       <= pos_nxt;
      cfs_r       <= cfs_nxt;
      fe_r        <= fe_nxt;
      win_r       <= win_nxt;
      bsm_r       <= bsm_nxt;
      lim_r       <= lim_nxt;
      pend_real_r <= pend_real_nxt;
      pend_pad_r  <= pend_pad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_byte_r   <= in_chan.byte_value;
      a_bvalid_r <= in_chan.byte_valid;
      a_end_r    <= in_chan.end_of_string;
    end
    pend_start_r <= pend_start_nxt;
    pend_end_r   <= pend_end_nxt;
    out_start_r  <= out_start_nxt;
    out_end_r    <= out_end_nxt;
    out_pad_r    <= out_pad_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.field_start = out_start_r;
  assign out_chan.field_end   = out_end_r;
  assign out_chan.is_padding  = out_pad_r;
  assign out_chan.last_result = out_last_r;

  // A string end leaves the per-string state cleared.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    consume_a && a_end_r |=> pos_r == '0 && fe_r == '0 && cfs_r == '0 && !lim_r)
    else $error("string state not cleared after string end");

  // While results of a string end drain, the input register must not advance.
  pend_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    pend_active |-> !consume_a)
    else $error("item consumed while results pending");

  a_field_order: assert property (@(posedge clk) disable iff (!rst_n)
    cfs_r <= pos_r)
    else $error("field start beyond byte position");

  pad_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_pad_r <= MIN_W'(MAX_RESULTS))
    else $error("padding count out of range");

  // Only the final result of a string end may close the string.
  last_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    pend_active && out_load_ok |=> !out_last_r || !pend_active)
    else $error("last result sent while results remain");

endmodule
